### src/agrg_pkg.sv
// Shared types, widths and constants for the affine grid row generator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package agrg_pkg;

  // Fixed-point format and grid limits.
  localparam int FRAC_BITS = 16;
  localparam int MAX_WIDTH = 64;

  // Field widths.
  localparam int COEF_W  = 32;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int RW_W    = 7;
  localparam int STEP_W  = 17;
  localparam int GAIN_W  = 31;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Derived datapath widths.
  localparam int PROD_W  = 64;                      // coefficient times gain
  localparam int POS_W   = COL_W + STEP_W;          // normalized position
  localparam int PPROD_W = POS_W + 1 + COEF_W;      // position times coefficient
  localparam int SUM_W   = PPROD_W - FRAC_BITS + 1; // shifted product plus offset

  // Register reset values.
  localparam logic [RW_W-1:0]   ROW_WIDTH_RST = RW_W'(64);
  localparam logic [STEP_W-1:0] X_STEP_RST    = STEP_W'(1040);
  localparam logic [STEP_W-1:0] Y_STEP_RST    = STEP_W'(1040);
  localparam logic [GAIN_W-1:0] COEF_GAIN_RST = GAIN_W'(65536);

  // 1.0 in the product domain, and the 32-bit saturation bounds.
  localparam logic signed [PROD_W-1:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh000000007FFFFFFF;
  localparam logic signed [PROD_W-1:0] S32_MIN = 64'shFFFFFFFF80000000;

  // Configuration register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    REG_ROW_WIDTH       = 3'd0,
    REG_X_STEP          = 3'd1,
    REG_Y_STEP          = 3'd2,
    REG_COEF_GAIN       = 3'd3,
    REG_IDENTITY_ADJUST = 3'd4
  } cfg_reg_t;

  // Saturate a signed value to the signed 32-bit range.
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[COEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/agrg_row_if.sv
// Valid/ready channel that carries one grid row transaction.
// Depends on agrg_pkg for the field widths.
`default_nettype none

interface agrg_row_if;
  logic                                valid;
  logic                                ready;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_xx;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_xy;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_xo;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_yx;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_yy;
  logic signed [agrg_pkg::COEF_W-1:0]  coef_yo;
  logic        [agrg_pkg::ROW_W-1:0]   row_index;

  modport source (
    output valid, coef_xx, coef_xy, coef_xo, coef_yx, coef_yy, coef_yo, row_index,
    input  ready
  );

  modport sink (
    input  valid, coef_xx, coef_xy, coef_xo, coef_yx, coef_yy, coef_yo, row_index,
    output ready
  );
endinterface

`default_nettype wire

### src/agrg_point_if.sv
// Valid/ready channel that carries one grid point transaction.
// Depends on agrg_pkg for the field widths.
`default_nettype none

interface agrg_point_if;
  logic                                valid;
  logic                                ready;
  logic        [agrg_pkg::COL_W-1:0]   column_index;
  logic signed [agrg_pkg::COEF_W-1:0]  x_coord;
  logic signed [agrg_pkg::COEF_W-1:0]  y_coord;
  logic                                last_point;

  modport source (
    output valid, column_index, x_coord, y_coord, last_point,
    input  ready
  );

  modport sink (
    input  valid, column_index, x_coord, y_coord, last_point,
    output ready
  );
endinterface

`default_nettype wire

### src/affine_grid_row_generator_unit.sv
// Top level of the affine grid row generator: register file, coefficient pipeline,
// column sequencer and point pipeline. Depends on agrg_pkg, agrg_row_if, agrg_point_if.
//
// Usage:
// - rows (valid/ready sink) takes one transaction per grid row: six Q16.16 affine
//   coefficients and a row index. points (valid/ready source) returns one transaction
//   per column, in column order, with last_point set on the final column.
// - The APB port writes and reads the five control registers at byte addresses 4*i.
//   The user must write registers only while no row is in flight; the block does not enforce this.
// - The first point of a row follows the accepted row through five more coefficient
//   stages, the sequencer and four point stages, the last of them the output register.
// - Throughput: one point per cycle while points.ready stays high. A row holds the
//   column sequencer until its last column issues, and the next row is taken then;
//   rows with a zero width produce nothing and pass at one per cycle.
// - Reset clears every valid bit and loads the register reset values.
// - When the receiver holds points.ready low with a point waiting, the whole
//   pipeline freezes in place and rows.ready drops; nothing is lost or repeated.
`default_nettype none

module affine_grid_row_generator_unit (
  input  wire                              clk,
  input  wire                              rst,
  agrg_row_if.sink                         rows,
  agrg_point_if.source                     points,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [agrg_pkg::ADDR_W-1:0]      paddr,
  input  wire  [agrg_pkg::DATA_W-1:0]      pwdata,
  output logic [agrg_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int NCOEF = 6;
  localparam int FB    = agrg_pkg::FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  logic [agrg_pkg::RW_W-1:0]    row_width;
  logic [agrg_pkg::STEP_W-1:0]  x_step;
  logic [agrg_pkg::STEP_W-1:0]  y_step;
  logic [agrg_pkg::GAIN_W-1:0]  coef_gain;
  logic                         identity_adjust;

  logic                         cfg_wr;
  agrg_pkg::cfg_reg_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = agrg_pkg::cfg_reg_t'(paddr[agrg_pkg::ADDR_W-1:2]);

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= agrg_pkg::ROW_WIDTH_RST;
      x_step          <= agrg_pkg::X_STEP_RST;
      y_step          <= agrg_pkg::Y_STEP_RST;
      coef_gain       <= agrg_pkg::COEF_GAIN_RST;
      identity_adjust <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        agrg_pkg::REG_ROW_WIDTH:       row_width       <= pwdata[agrg_pkg::RW_W-1:0];
        agrg_pkg::REG_X_STEP:          x_step          <= pwdata[agrg_pkg::STEP_W-1:0];
        agrg_pkg::REG_Y_STEP:          y_step          <= pwdata[agrg_pkg::STEP_W-1:0];
        agrg_pkg::REG_COEF_GAIN:       coef_gain       <= pwdata[agrg_pkg::GAIN_W-1:0];
        agrg_pkg::REG_IDENTITY_ADJUST: identity_adjust <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (cfg_sel)
      agrg_pkg::REG_ROW_WIDTH:       prdata = agrg_pkg::DATA_W'(row_width);
      agrg_pkg::REG_X_STEP:          prdata = agrg_pkg::DATA_W'(x_step);
      agrg_pkg::REG_Y_STEP:          prdata = agrg_pkg::DATA_W'(y_step);
      agrg_pkg::REG_COEF_GAIN:       prdata = agrg_pkg::DATA_W'(coef_gain);
      agrg_pkg::REG_IDENTITY_ADJUST: prdata = agrg_pkg::DATA_W'(identity_adjust);
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------
  logic o_valid;
  logic adv;        // point pipeline and sequencer move
  logic fen;        // coefficient pipeline moves
  logic seq_free;   // sequencer can take a new row this cycle
  logic last_issue;
  logic f6_valid;

  assign adv        = !o_valid || points.ready;
  assign fen        = adv && (!f6_valid || seq_free);
  assign rows.ready = fen;

  // ---------------------------------------------------------------------------
  // Coefficient pipeline
  // ---------------------------------------------------------------------------
  logic f1_valid, f2_valid, f3_valid, f4_valid, f5_valid;

  logic signed [agrg_pkg::COEF_W-1:0]  f1_coef [NCOEF];
  logic        [agrg_pkg::ROW_W-1:0]   f1_row;
  logic signed [agrg_pkg::PROD_W-1:0]  f2_prod [NCOEF];
  logic        [agrg_pkg::POS_W-1:0]   f2_yp;
  logic signed [agrg_pkg::COEF_W-1:0]  f3_coef [NCOEF];
  logic        [agrg_pkg::POS_W-1:0]   f3_yp;
  logic signed [agrg_pkg::COEF_W-1:0]  f4_coef [NCOEF];
  logic        [agrg_pkg::POS_W-1:0]   f4_yp;
  logic signed [agrg_pkg::PPROD_W-1:0] f5_pyx, f5_pyy;
  logic signed [agrg_pkg::COEF_W-1:0]  f5_c0, f5_c2, f5_c3, f5_c5;
  logic signed [agrg_pkg::SUM_W-1:0]   f6_cx, f6_cy;
  logic signed [agrg_pkg::COEF_W-1:0]  f6_c0, f6_c3;

  logic signed [agrg_pkg::COEF_W-1:0]  gain_s;

  assign gain_s = $signed({1'b0, coef_gain});

  // Valid bits of the coefficient pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
      f5_valid <= 1'b0;
      f6_valid <= 1'b0;
    end else if (fen) begin
      f1_valid <= rows.valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
      f5_valid <= f4_valid;
      f6_valid <= f5_valid;
    end
  end

  // Stage 1 captures the row; stage 2 scales by the gain and forms the row position;
  // stage 3 truncates and saturates; stage 4 applies the identity adjust; stage 5
  // multiplies by the row position; stage 6 folds in the offsets.
  always_ff @(posedge clk) begin
    if (fen) begin
      f1_coef[0] <= rows.coef_xx;
      f1_coef[1] <= rows.coef_xy;
      f1_coef[2] <= rows.coef_xo;
      f1_coef[3] <= rows.coef_yx;
      f1_coef[4] <= rows.coef_yy;
      f1_coef[5] <= rows.coef_yo;
      f1_row     <= rows.row_index;

      for (int i = 0; i < NCOEF; i++) begin
        f2_prod[i] <= f1_coef[i] * gain_s;
        f3_coef[i] <= agrg_pkg::sat32(f2_prod[i] >>> FB);
      end
      f2_yp <= f1_row * y_step;
      f3_yp <= f2_yp;

      for (int i = 0; i < NCOEF; i++) begin
        f4_coef[i] <= f3_coef[i];
      end
      if (identity_adjust) begin
        f4_coef[0] <= agrg_pkg::sat32(agrg_pkg::PROD_W'(f3_coef[0]) + agrg_pkg::ONE_Q);
        f4_coef[4] <= agrg_pkg::sat32(agrg_pkg::PROD_W'(f3_coef[4]) + agrg_pkg::ONE_Q);
      end
      f4_yp <= f3_yp;

      f5_pyx <= $signed({1'b0, f4_yp}) * f4_coef[1];
      f5_pyy <= $signed({1'b0, f4_yp}) * f4_coef[4];
      f5_c0  <= f4_coef[0];
      f5_c2  <= f4_coef[2];
      f5_c3  <= f4_coef[3];
      f5_c5  <= f4_coef[5];

      f6_cx <= agrg_pkg::SUM_W'(f5_pyx >>> FB) + agrg_pkg::SUM_W'(f5_c2);
      f6_cy <= agrg_pkg::SUM_W'(f5_pyy >>> FB) + agrg_pkg::SUM_W'(f5_c5);
      f6_c0 <= f5_c0;
      f6_c3 <= f5_c3;
    end
  end

  // ---------------------------------------------------------------------------
  // Column sequencer: holds one row and, while not stalled, issues one column per cycle
  // ---------------------------------------------------------------------------
  logic                               s_valid;
  logic [agrg_pkg::COL_W-1:0]         s_col;
  logic [agrg_pkg::RW_W-1:0]          s_n;
  logic signed [agrg_pkg::COEF_W-1:0] s_c0, s_c3;
  logic signed [agrg_pkg::SUM_W-1:0]  s_cx, s_cy;
  logic [agrg_pkg::RW_W-1:0]          n_eff;

  assign n_eff = (row_width > agrg_pkg::RW_W'(agrg_pkg::MAX_WIDTH))
               ? agrg_pkg::RW_W'(agrg_pkg::MAX_WIDTH) : row_width;

  assign last_issue = s_valid && ((agrg_pkg::RW_W'(s_col) + 1'b1) == s_n);
  assign seq_free   = !s_valid || last_issue;

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_col   <= '0;
    end else if (adv) begin
      if (seq_free) begin
        s_valid <= f6_valid && (n_eff != '0);
        s_col   <= '0;
      end else begin
        s_col   <= s_col + 1'b1;
      end
    end
  end

  // Row descriptor load.
  always_ff @(posedge clk) begin
    if (adv && seq_free && f6_valid) begin
      s_n  <= n_eff;
      s_c0 <= f6_c0;
      s_c3 <= f6_c3;
      s_cx <= f6_cx;
      s_cy <= f6_cy;
    end
  end

  // ---------------------------------------------------------------------------
  // Point pipeline
  // ---------------------------------------------------------------------------
  logic c1_valid, c2_valid, c3_valid;

  logic [agrg_pkg::COL_W-1:0]          c1_col, c2_col, c3_col, o_col;
  logic                                c1_last, c2_last, c3_last, o_last;
  logic [agrg_pkg::POS_W-1:0]          c1_xp;
  logic signed [agrg_pkg::COEF_W-1:0]  c1_c0, c1_c3;
  logic signed [agrg_pkg::SUM_W-1:0]   c1_cx, c1_cy, c2_cx, c2_cy;
  logic signed [agrg_pkg::PPROD_W-1:0] c2_px, c2_py;
  logic signed [agrg_pkg::SUM_W-1:0]   c3_sx, c3_sy;
  logic signed [agrg_pkg::COEF_W-1:0]  o_x, o_y;

  // Valid bits of the point pipeline and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      c1_valid <= s_valid;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
      o_valid  <= c3_valid;
    end
  end

  // Column position, products, sums and saturation, one register stage each.
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_col  <= s_col;
      c1_last <= last_issue;
      c1_xp   <= s_col * x_step;
      c1_c0   <= s_c0;
      c1_c3   <= s_c3;
      c1_cx   <= s_cx;
      c1_cy   <= s_cy;

      c2_col  <= c1_col;
      c2_last <= c1_last;
      c2_px   <= $signed({1'b0, c1_xp}) * c1_c0;
      c2_py   <= $signed({1'b0, c1_xp}) * c1_c3;
      c2_cx   <= c1_cx;
      c2_cy   <= c1_cy;

      c3_col  <= c2_col;
      c3_last <= c2_last;
      c3_sx   <= agrg_pkg::SUM_W'(c2_px >>> FB) + c2_cx;
      c3_sy   <= agrg_pkg::SUM_W'(c2_py >>> FB) + c2_cy;

      o_col   <= c3_col;
      o_last  <= c3_last;
      o_x     <= agrg_pkg::sat32(agrg_pkg::PROD_W'(c3_sx));
      o_y     <= agrg_pkg::sat32(agrg_pkg::PROD_W'(c3_sy));
    end
  end

  assign points.valid        = o_valid;
  assign points.column_index = o_col;
  assign points.x_coord      = o_x;
  assign points.y_coord      = o_y;
  assign points.last_point   = o_last;

endmodule

`default_nettype wire

### src/agrg_checker.sv
// Port-level checks of the affine grid row generator, bound to its top level.
// Depends on agrg_pkg and on the top level affine_grid_row_generator_unit.
`default_nettype none

module agrg_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          pt_valid,
  input wire                          pt_ready,
  input wire [agrg_pkg::COL_W-1:0]    pt_col,
  input wire [agrg_pkg::COEF_W-1:0]   pt_x,
  input wire                          pt_last
);

  // Column expected on the next point transaction.
  logic [agrg_pkg::COL_W-1:0] col_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_exp <= '0;
    end else if (pt_valid && pt_ready) begin
      col_exp <= pt_last ? '0 : pt_col + 1'b1;
    end
  end

  // No point is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !pt_valid)
    else $error("point offered right after reset");

  // Points of a row come in column order starting from zero.
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    pt_valid |-> pt_col == col_exp)
    else $error("point column out of order");

  // A row never exceeds the widest grid, so the top column is always the last.
  a_top_last: assert property (@(posedge clk) disable iff (rst)
    pt_valid && (pt_col == agrg_pkg::COL_W'(agrg_pkg::MAX_WIDTH - 1)) |-> pt_last)
    else $error("top column not marked last");

  // A stalled point stays offered with its column and x coordinate unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_ready |=> pt_valid && $stable(pt_col) && $stable(pt_x))
    else $error("stalled point changed");

endmodule

bind affine_grid_row_generator_unit agrg_checker u_agrg_checker (
  .clk      (clk),
  .rst      (rst),
  .pt_valid (points.valid),
  .pt_ready (points.ready),
  .pt_col   (points.column_index),
  .pt_x     (points.x_coord),
  .pt_last  (points.last_point)
);

`default_nettype wire

### tb/grid_point_checker.sv
// Grid point checker: mirrors the register writes on the APB port, predicts the
// points of every accepted row and compares them with the points the unit emits.
// Depends on agrg_pkg and on the agrg_row_if and agrg_point_if interfaces.
module grid_point_checker (
  input  wire                         clk,
  input  wire                         rst,
  agrg_row_if                         rows,
  agrg_point_if                       points,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire                         pready,
  input  wire  [agrg_pkg::ADDR_W-1:0] paddr,
  input  wire  [agrg_pkg::DATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending,
  output int                          rows_seen,
  output int                          points_seen
);
  import agrg_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]         column_index;
    logic signed [COEF_W-1:0] x_coord;
    logic signed [COEF_W-1:0] y_coord;
    logic                     last_point;
  } grid_point_t;

  localparam longint I32_HI = 64'sh7FFFFFFF;
  localparam longint I32_LO = -64'sh80000000;
  localparam longint UNITY  = 64'sd1 << FRAC_BITS;

  // Local copy of the control registers.
  logic [RW_W-1:0]   width_q;
  logic [STEP_W-1:0] xstep_q;
  logic [STEP_W-1:0] ystep_q;
  logic [GAIN_W-1:0] gain_q;
  logic              ident_q;

  // Points still owed by the unit, oldest first.
  grid_point_t due_points[$];

  logic signed [COEF_W-1:0] coef_in [6];
  grid_point_t              want;

  initial begin
    errors      = 0;
    pending     = 0;
    rows_seen   = 0;
    points_seen = 0;
  end

  function automatic longint clip_s32(input longint v);
    if (v > I32_HI) begin
      return I32_HI;
    end else if (v < I32_LO) begin
      return I32_LO;
    end
    return v;
  endfunction

  // Coefficient times the unsigned Q15.16 gain, floored and clipped to 32 bits.
  function automatic longint scale_coef(input logic signed [COEF_W-1:0] c);
    longint gl;
    gl = 0;
    gl[GAIN_W-1:0] = gain_q;
    return clip_s32((longint'(c) * gl) >>> FRAC_BITS);
  endfunction

  // Works out every point of one row and queues it in column order.
  function automatic void compute_grid_row(input logic signed [COEF_W-1:0] cin [6],
                                           input logic [ROW_W-1:0] row);
    longint      c [6];
    longint      yp;
    longint      xp;
    longint      base_x;
    longint      base_y;
    longint      xv;
    longint      yv;
    int          n;
    grid_point_t pt;
    for (int i = 0; i < 6; i++) begin
      c[i] = scale_coef(cin[i]);
    end
    if (ident_q) begin
      c[0] = clip_s32(c[0] + UNITY);
      c[4] = clip_s32(c[4] + UNITY);
    end
    n = (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    yp = longint'(row) * longint'(ystep_q);
    base_x = ((yp * c[1]) >>> FRAC_BITS) + c[2];
    base_y = ((yp * c[4]) >>> FRAC_BITS) + c[5];
    for (int col = 0; col < n; col++) begin
      xp = longint'(col) * longint'(xstep_q);
      xv = clip_s32(((xp * c[0]) >>> FRAC_BITS) + base_x);
      yv = clip_s32(((xp * c[3]) >>> FRAC_BITS) + base_y);
      pt.column_index = col[COL_W-1:0];
      pt.x_coord      = xv[COEF_W-1:0];
      pt.y_coord      = yv[COEF_W-1:0];
      pt.last_point   = (col == n - 1);
      due_points.push_back(pt);
    end
  endfunction

  // Register writes first, then row transactions, then point transactions.
  always @(posedge clk) begin
    if (rst) begin
      width_q = ROW_WIDTH_RST;
      xstep_q = X_STEP_RST;
      ystep_q = Y_STEP_RST;
      gain_q  = COEF_GAIN_RST;
      ident_q = 1'b0;
      due_points.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[ADDR_W-1:2]))
          REG_ROW_WIDTH:       width_q = pwdata[RW_W-1:0];
          REG_X_STEP:          xstep_q = pwdata[STEP_W-1:0];
          REG_Y_STEP:          ystep_q = pwdata[STEP_W-1:0];
          REG_COEF_GAIN:       gain_q  = pwdata[GAIN_W-1:0];
          REG_IDENTITY_ADJUST: ident_q = pwdata[0];
          default: ;
        endcase
      end

      if (rows.valid && rows.ready) begin
        coef_in[0] = rows.coef_xx;
        coef_in[1] = rows.coef_xy;
        coef_in[2] = rows.coef_xo;
        coef_in[3] = rows.coef_yx;
        coef_in[4] = rows.coef_yy;
        coef_in[5] = rows.coef_yo;
        compute_grid_row(coef_in, rows.row_index);
        rows_seen++;
      end

      if (points.valid && points.ready) begin
        points_seen++;
        if (due_points.size() == 0) begin
          $error("unexpected point transaction at column %0d", points.column_index);
          errors++;
        end else begin
          want = due_points.pop_front();
          if (points.column_index !== want.column_index) begin
            $error("column_index mismatch: expected %0d, actual %0d",
                   want.column_index, points.column_index);
            errors++;
          end
          if (points.x_coord !== want.x_coord) begin
            $error("x_coord mismatch: expected %0d, actual %0d",
                   want.x_coord, points.x_coord);
            errors++;
          end
          if (points.y_coord !== want.y_coord) begin
            $error("y_coord mismatch: expected %0d, actual %0d",
                   want.y_coord, points.y_coord);
            errors++;
          end
          if (points.last_point !== want.last_point) begin
            $error("last_point mismatch: expected %0d, actual %0d",
                   want.last_point, points.last_point);
            errors++;
          end
        end
      end
    end
    pending = due_points.size();
  end

endmodule

### tb/tb_affine_grid_row_generator_unit.sv
// Testbench top for the affine grid row generator: clock, reset, row and register
// stimulus, random back-pressure and the verdict. Depends on agrg_pkg, the two
// channel interfaces, the unit itself and grid_point_checker.
module tb_affine_grid_row_generator_unit;
  import agrg_pkg::*;

  localparam logic signed [COEF_W-1:0] CMAX = 32'sh7FFFFFFF;
  localparam logic signed [COEF_W-1:0] CMIN = 32'sh80000000;
  localparam int IDLE_PCT = 34;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              calm;

  int errors;
  int pending;
  int rows_seen;
  int points_seen;
  int settings_used;

  agrg_row_if   rows_ch();
  agrg_point_if points_ch();

  affine_grid_row_generator_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows_ch),
    .points  (points_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  grid_point_checker point_check (
    .clk         (clk),
    .rst         (rst),
    .rows        (rows_ch),
    .points      (points_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .pending     (pending),
    .rows_seen   (rows_seen),
    .points_seen (points_seen)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Receiver back-pressure, switched off during the calm stretch.
  always @(negedge clk) begin
    points_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input cfg_reg_t sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [RW_W-1:0] w, input logic [STEP_W-1:0] xs,
                            input logic [STEP_W-1:0] ys, input logic [GAIN_W-1:0] g,
                            input logic id);
    write_reg(REG_ROW_WIDTH, DATA_W'(w));
    write_reg(REG_X_STEP, DATA_W'(xs));
    write_reg(REG_Y_STEP, DATA_W'(ys));
    write_reg(REG_COEF_GAIN, DATA_W'(g));
    write_reg(REG_IDENTITY_ADJUST, DATA_W'(id));
    settings_used++;
  endtask

  // Offers one row transaction, with random idle cycles ahead of it.
  task automatic send_row(input logic signed [COEF_W-1:0] xx, input logic signed [COEF_W-1:0] xy,
                          input logic signed [COEF_W-1:0] xo, input logic signed [COEF_W-1:0] yx,
                          input logic signed [COEF_W-1:0] yy, input logic signed [COEF_W-1:0] yo,
                          input logic [ROW_W-1:0] row);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      rows_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rows_ch.valid     <= 1'b1;
    rows_ch.coef_xx   <= xx;
    rows_ch.coef_xy   <= xy;
    rows_ch.coef_xo   <= xo;
    rows_ch.coef_yx   <= yx;
    rows_ch.coef_yy   <= yy;
    rows_ch.coef_yo   <= yo;
    rows_ch.row_index <= row;
    do @(posedge clk); while (!rows_ch.ready);
    @(negedge clk);
  endtask

  // Drains every owed point, then leaves room for rows that emit nothing.
  task automatic settle();
    rows_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Mix of extremes, full-range words and small fixed-point values.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9)) inside
      0:       return CMAX;
      1:       return CMIN;
      [2:4]:   return $urandom;
      default: return $signed($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  task automatic send_random_row();
    send_row(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
             ROW_W'($urandom_range(0, 63)));
  endtask

  // Stimulus.
  initial begin
    int                counted;
    int                n;
    int                phase;
    logic [RW_W-1:0]   w;
    logic [STEP_W-1:0] xs;
    logic [STEP_W-1:0] ys;
    logic [GAIN_W-1:0] g;

    rst               = 1'b1;
    calm              = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rows_ch.valid     = 1'b0;
    rows_ch.coef_xx   = '0;
    rows_ch.coef_xy   = '0;
    rows_ch.coef_xo   = '0;
    rows_ch.coef_yx   = '0;
    rows_ch.coef_yy   = '0;
    rows_ch.coef_yo   = '0;
    rows_ch.row_index = '0;
    points_ch.ready   = 1'b0;
    settings_used     = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: full-width rows with field extremes and bit patterns.
    send_row('0, '0, '0, '0, '0, '0, 6'd0);
    send_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 6'd63);
    send_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 6'd63);
    send_row(32'sd65536, '0, '0, '0, 32'sd65536, '0, 6'd31);
    send_row(32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA,
             32'shAAAAAAAA, 6'd42);
    send_row(32'sh55555555, 32'sh55555555, 32'sh55555555, 32'sh55555555, 32'sh55555555,
             32'sh55555555, 6'd21);
    settle();

    // Width above the maximum, steps beyond one, largest gain so scaling clips.
    set_config(7'd127, 17'd131071, 17'd131071, 31'h7FFFFFFF, 1'b1);
    send_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 6'd63);
    send_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 6'd0);
    send_row(32'sd3, -32'sd5, 32'sd7, -32'sd1, 32'sd0, 32'sd2, 6'd17);
    send_row('0, '0, '0, '0, '0, '0, 6'd63);
    settle();

    // Zero width: rows are taken but emit no points.
    set_config(7'd0, 17'd1040, 17'd1040, 31'd65536, 1'b0);
    repeat (3) send_random_row();
    settle();

    // Single column, zero steps and zero gain: only the identity term survives.
    set_config(7'd1, 17'd0, 17'd0, 31'd0, 1'b1);
    send_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 6'd63);
    send_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 6'd5);
    settle();

    // Unit gain with the identity add clipping at the top of the range.
    set_config(7'd2, 17'd65536, 17'd65536, 31'd65536, 1'b1);
    send_row(CMAX, '0, '0, '0, CMAX, '0, 6'd1);
    send_row(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 6'd63);
    settle();

    // Random settings, each followed by a burst of random rows.
    counted = 0;
    phase   = 0;
    while (counted < 128) begin
      case ($urandom_range(0, 9))
        0:       w = 7'd0;
        1:       w = 7'd1;
        2:       w = 7'd64;
        3:       w = RW_W'($urandom_range(65, 127));
        default: w = RW_W'($urandom_range(2, 20));
      endcase
      case ($urandom_range(0, 7))
        0:       xs = 17'd0;
        1:       xs = 17'd65536;
        2:       xs = STEP_W'($urandom_range(65537, 131071));
        3:       xs = 17'd131071;
        default: xs = (w > 1) ? STEP_W'(65536 / (int'(w) - 1)) : 17'd65536;
      endcase
      case ($urandom_range(0, 7))
        0:       ys = 17'd0;
        1:       ys = 17'd131071;
        2:       ys = STEP_W'($urandom_range(0, 131071));
        default: ys = STEP_W'(65536 / $urandom_range(1, 63));
      endcase
      case ($urandom_range(0, 7))
        0:       g = 31'd0;
        1:       g = 31'h7FFFFFFF;
        2:       g = GAIN_W'($urandom);
        3:       g = GAIN_W'($urandom_range(32768, 131072));
        default: g = 31'd65536;
      endcase
      calm = (phase == 3);
      set_config(w, xs, ys, g, 1'($urandom_range(0, 1)));
      n = $urandom_range(6, 18);
      repeat (n) send_random_row();
      settle();
      counted += n;
      phase++;
    end
    calm = 1'b0;

    $display("Summary: %0d rows under %0d register settings, %0d points compared.",
             rows_seen, settings_used, points_seen);
    $display("Settings included zero and oversized widths, steps past one and clipping gains.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
src/agrg_pkg.sv
src/agrg_row_if.sv
src/agrg_point_if.sv
src/affine_grid_row_generator_unit.sv
src/agrg_checker.sv
tb/grid_point_checker.sv
tb/tb_affine_grid_row_generator_unit.sv
